### sv/cswb_pkg.sv
// Shared types and constants for the clock sweep buffer replacer.
// No dependencies; every other file in sv/ imports this package.
package cswb_pkg;

   localparam int FRAMES    = 16;
   localparam int USAGE_CAP = 5;
   localparam int FIDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int USAGE_W   = $clog2(USAGE_CAP + 1);
   localparam int BUDGET    = FRAMES * (USAGE_CAP + 1);
   localparam int CNT_W     = $clog2(BUDGET + 1);

   localparam logic [1:0] OP_ACCESS  = 2'd0;
   localparam logic [1:0] OP_PIN     = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] ST_HIT    = 2'd0;
   localparam logic [1:0] ST_MISS   = 2'd1;
   localparam logic [1:0] ST_NONE   = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] page_id;
      logic        pin_flag;
      logic        dirty_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  frame;
      logic        evicted_valid;
      logic [31:0] evicted_page;
      logic        writeback;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic start_sweep;
      logic step;
      logic install;
      logic no_victim;
   } cmd_type;

   typedef struct packed {
      logic access_miss;
      logic sweep_term;
      logic budget_done;
   } stat_type;

endpackage

### sv/cswb_dp.sv
// Datapath: frame tags, flags, usage counts, clock hand, sweep budget and result register.
// Depends on cswb_pkg; driven by commands from cswb_ctrl.
module cswb_dp (
   input  logic             clock,
   input  logic             reset,
   input  cswb_pkg::req_type req_payload,
   input  cswb_pkg::cmd_type cmd,
   output cswb_pkg::stat_type stat,
   output cswb_pkg::rsp_type rsp_payload
);
   import cswb_pkg::*;

   logic [31:0]        tag_ff [FRAMES];
   logic [FRAMES-1:0]  valid_ff, valid_in;
   logic [FRAMES-1:0]  pinned_ff, pinned_in;
   logic [FRAMES-1:0]  dirty_ff, dirty_in;
   logic [USAGE_W-1:0] usage_ff [FRAMES];
   logic [USAGE_W-1:0] usage_in [FRAMES];
   logic [FIDX_W-1:0]  hand_ff, hand_in, hand_next;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   req_type            req_ff;
   rsp_type            rsp_ff, rsp_in;

   logic              hit;
   logic [FIDX_W-1:0] hit_idx;

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == req_ff.page_id) begin
            hit     = 1'b1;
            hit_idx = FIDX_W'(i);
         end
      end
   end

   assign hand_next = (hand_ff == FIDX_W'(FRAMES - 1)) ? '0 : hand_ff + 1'b1;

   assign stat.access_miss = (req_ff.op == OP_ACCESS) && !hit;
   assign stat.sweep_term  = !pinned_ff[hand_ff] &&
                             (!valid_ff[hand_ff] || usage_ff[hand_ff] == '0);
   assign stat.budget_done = (cnt_ff == CNT_W'(BUDGET));

   always_comb begin
      valid_in  = valid_ff;
      pinned_in = pinned_ff;
      dirty_in  = dirty_ff;
      usage_in  = usage_ff;
      hand_in   = hand_ff;
      cnt_in    = cnt_ff;
      rsp_in    = rsp_ff;
      if (cmd.exec) begin
         rsp_in = '0;
         rsp_in.status = ST_ABSENT;
         if (hit && (req_ff.op == OP_ACCESS || req_ff.op == OP_PIN ||
                     req_ff.op == OP_RELEASE)) begin
            rsp_in.status = ST_HIT;
            rsp_in.frame  = 4'(hit_idx);
            unique case (req_ff.op)
               OP_ACCESS: begin
                  if (usage_ff[hit_idx] < USAGE_W'(USAGE_CAP))
                     usage_in[hit_idx] = usage_ff[hit_idx] + 1'b1;
                  else
                     usage_in[hit_idx] = USAGE_W'(USAGE_CAP);
                  pinned_in[hit_idx] = pinned_ff[hit_idx] | req_ff.pin_flag;
               end
               OP_PIN: pinned_in[hit_idx] = 1'b1;
               default: begin
                  pinned_in[hit_idx] = 1'b0;
                  dirty_in[hit_idx]  = dirty_ff[hit_idx] | req_ff.dirty_flag;
               end
            endcase
         end
      end
      if (cmd.start_sweep)
         cnt_in = '0;
      if (cmd.step) begin
         if (!pinned_ff[hand_ff])
            usage_in[hand_ff] = usage_ff[hand_ff] - 1'b1;
         hand_in = hand_next;
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.install) begin
         rsp_in               = '0;
         rsp_in.status        = ST_MISS;
         rsp_in.frame         = 4'(hand_ff);
         rsp_in.evicted_valid = valid_ff[hand_ff];
         rsp_in.evicted_page  = valid_ff[hand_ff] ? tag_ff[hand_ff] : '0;
         rsp_in.writeback     = valid_ff[hand_ff] & dirty_ff[hand_ff];
         valid_in[hand_ff]    = 1'b1;
         usage_in[hand_ff]    = USAGE_W'(1);
         pinned_in[hand_ff]   = req_ff.pin_flag;
         dirty_in[hand_ff]    = 1'b0;
         hand_in              = hand_next;
      end
      if (cmd.no_victim) begin
         rsp_in        = '0;
         rsp_in.status = ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         pinned_ff <= '0;
         dirty_ff  <= '0;
         hand_ff   <= '0;
         cnt_ff    <= '0;
         for (int i = 0; i < FRAMES; i++) usage_ff[i] <= '0;
      end else begin
         valid_ff  <= valid_in;
         pinned_ff <= pinned_in;
         dirty_ff  <= dirty_in;
         hand_ff   <= hand_in;
         cnt_ff    <= cnt_in;
         usage_ff  <= usage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_payload;
      if (cmd.install) tag_ff[hand_ff] <= req_ff.page_id;
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

### sv/cswb_ctrl.sv
// Controller: request handshake, sequencing of lookup and sweep, result valid.
// Depends on cswb_pkg; issues commands to cswb_dp.
module cswb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  cswb_pkg::stat_type stat,
   output cswb_pkg::cmd_type  cmd
);
   import cswb_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SWEEP} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.access_miss) begin
               cmd.start_sweep = 1'b1;
               state_in        = S_SWEEP;
            end else if (out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            priority if (stat.budget_done) begin
               if (out_free) begin
                  cmd.no_victim = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (stat.sweep_term) begin
               if (out_free) begin
                  cmd.install = 1'b1;
                  state_in    = S_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
      endcase
   end

   assign load = cmd.exec | cmd.install | cmd.no_victim;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/clock_sweep_buffer_replacer_core.sv
// Clock sweep buffer replacer, top level: one request beat at a time.
// Hit, pin, release: result loads in the exec state after the accepted beat, once the output is free.
// Miss: result loads after a sweep of at most 96 frames; all pinned: budget runs out, no victim.
// One frame per cycle; next beat taken the cycle after the result loads; stalled result holds it.
// Synchronous reset clears flags, usage counts and hand; tags hold until written.
// Depends on cswb_pkg, cswb_ctrl, cswb_dp.
module clock_sweep_buffer_replacer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cswb_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cswb_pkg::rsp_type rsp_payload
);
   import cswb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cswb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cswb_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous beat still in work");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.evicted_valid) |-> (rsp_payload.status == ST_MISS))
      else $error("eviction reported outside a miss");

   a_wb_needs_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.writeback) |-> rsp_payload.evicted_valid)
      else $error("writeback without evicted page");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.install, cmd.no_victim, cmd.step}))
      else $error("conflicting datapath commands");

endmodule

### tb/sv/tb_clock_sweep_buffer_replacer_core.sv
`timescale 1ns / 1ps
// Testbench for clock_sweep_buffer_replacer_core: random and directed frame requests,
// checked beat by beat against a clock-sweep frame table kept here.
// Depends on cswb_pkg and the core RTL.
module tb_clock_sweep_buffer_replacer_core;
   import cswb_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int POOL_SIZE    = 24;
   localparam int HOT_PAGES    = 8;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 110;
   localparam int HOLD_CYCLES  = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   clock_sweep_buffer_replacer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // frame table mirror
   logic [31:0]        tag_mirror    [FRAMES];
   logic               valid_mirror  [FRAMES];
   logic [USAGE_W-1:0] usage_mirror  [FRAMES];
   logic               pinned_mirror [FRAMES];
   logic               dirty_mirror  [FRAMES];
   int                 hand_mirror;

   rsp_type     expected_rsps[$];
   logic [31:0] page_pool [POOL_SIZE];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_left;
   int          error_count;
   int          beats_sent;
   int          beats_checked;
   int          hit_count;
   int          load_count;
   int          evict_count;
   int          writeback_count;
   int          all_pinned_count;
   int          absent_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type predict_frame_op(input req_type r);
      rsp_type res;
      int      hit;
      int      victim;
      int      cur;
      int      i;
      int      n;
      res        = '0;
      res.status = ST_ABSENT;
      hit        = -1;
      for (i = FRAMES - 1; i >= 0; i--) begin
         if (valid_mirror[i] && tag_mirror[i] == r.page_id) hit = i;
      end
      case (r.op)
         OP_ACCESS: begin
            if (hit >= 0) begin
               if (usage_mirror[hit] < USAGE_CAP) usage_mirror[hit]++;
               pinned_mirror[hit] = pinned_mirror[hit] | r.pin_flag;
               res.status = ST_HIT;
               res.frame  = 4'(hit);
            end else begin
               victim = -1;
               for (n = 0; n < BUDGET && victim < 0; n++) begin
                  cur         = hand_mirror;
                  hand_mirror = (cur + 1) % FRAMES;
                  if (!pinned_mirror[cur]) begin
                     if (!valid_mirror[cur] || usage_mirror[cur] == 0) victim = cur;
                     else usage_mirror[cur]--;
                  end
               end
               if (victim < 0) begin
                  res.status = ST_NONE;
               end else begin
                  if (valid_mirror[victim]) begin
                     res.evicted_valid = 1'b1;
                     res.evicted_page  = tag_mirror[victim];
                     res.writeback     = dirty_mirror[victim];
                  end
                  tag_mirror[victim]    = r.page_id;
                  valid_mirror[victim]  = 1'b1;
                  usage_mirror[victim]  = USAGE_W'(1);
                  pinned_mirror[victim] = r.pin_flag;
                  dirty_mirror[victim]  = 1'b0;
                  res.status            = ST_MISS;
                  res.frame             = 4'(victim);
               end
            end
         end
         OP_PIN, OP_RELEASE: begin
            if (hit >= 0) begin
               if (r.op == OP_PIN) begin
                  pinned_mirror[hit] = 1'b1;
               end else begin
                  pinned_mirror[hit] = 1'b0;
                  dirty_mirror[hit]  = dirty_mirror[hit] | r.dirty_flag;
               end
               res.status = ST_HIT;
               res.frame  = 4'(hit);
            end
         end
         default: res.status = ST_ABSENT;
      endcase
      return res;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [31:0] page,
                                        input logic pin, input logic dirty);
      req_type r;
      r.op         = op;
      r.page_id    = page;
      r.pin_flag   = pin;
      r.dirty_flag = dirty;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 60)      r.op = OP_ACCESS;
      else if (pick < 72) r.op = OP_PIN;
      else if (pick < 95) r.op = OP_RELEASE;
      else                r.op = OP_UNUSED;
      pick = $urandom_range(99);
      if (pick < 45)      r.page_id = page_pool[$urandom_range(HOT_PAGES - 1)];
      else if (pick < 88) r.page_id = page_pool[$urandom_range(POOL_SIZE - 1)];
      else                r.page_id = $urandom;
      r.pin_flag   = (r.op == OP_ACCESS) ? ($urandom_range(9) == 0) : 1'($urandom);
      r.dirty_flag = 1'($urandom);
      return r;
   endfunction

   task automatic send_beat(input req_type item);
      rsp_type exp_rsp;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      exp_rsp = predict_frame_op(item);
      expected_rsps.push_back(exp_rsp);
      beats_sent++;
      case (exp_rsp.status)
         ST_HIT:  hit_count++;
         ST_MISS: load_count++;
         ST_NONE: all_pinned_count++;
         default: absent_count++;
      endcase
      if (exp_rsp.evicted_valid) evict_count++;
      if (exp_rsp.writeback) writeback_count++;
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 20)
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result beat", 32'(rsp_payload.status), 32'hffff_ffff);
         end else begin
            want = expected_rsps.pop_front();
            beats_checked++;
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.frame !== want.frame)
               report_mismatch("frame", 32'(rsp_payload.frame), 32'(want.frame));
            if (rsp_payload.evicted_valid !== want.evicted_valid)
               report_mismatch("evicted_valid", 32'(rsp_payload.evicted_valid),
                               32'(want.evicted_valid));
            if (rsp_payload.evicted_page !== want.evicted_page)
               report_mismatch("evicted_page", rsp_payload.evicted_page, want.evicted_page);
            if (rsp_payload.writeback !== want.writeback)
               report_mismatch("writeback", 32'(rsp_payload.writeback), 32'(want.writeback));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("clock_sweep_buffer_replacer_core verification failed");
      $finish;
   end

   // extremes of page id, usage climb, pin/release hits and misses, unused op
   task automatic test_basic_ops();
      send_beat(make_req(OP_ACCESS, 32'h0000_0000, 1'b0, 1'b1));
      send_beat(make_req(OP_ACCESS, 32'hffff_ffff, 1'b0, 1'b0));
      repeat (3) send_beat(make_req(OP_ACCESS, 32'h0000_0000, 1'b0, 1'b0));
      send_beat(make_req(OP_PIN, 32'h0000_0001, 1'b1, 1'b1));
      send_beat(make_req(OP_RELEASE, 32'hffff_ffff, 1'b1, 1'b1));
      send_beat(make_req(OP_RELEASE, 32'h0000_0000, 1'b0, 1'b0));
      send_beat(make_req(OP_UNUSED, 32'h0000_0000, 1'b1, 1'b1));
      end_burst();
   endtask

   // pin every frame, then miss with nothing left to evict
   task automatic test_all_pinned();
      int i;
      for (i = 0; i < FRAMES; i++) send_beat(make_req(OP_ACCESS, page_pool[i], 1'b1, 1'b0));
      send_beat(make_req(OP_ACCESS, page_pool[FRAMES], 1'b0, 1'b0));
      end_burst();
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_beat(random_req());
      end_burst();
   endtask

   // hold the result side long enough to back up the request side
   task automatic test_backpressure();
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      repeat (20) send_beat(random_req());
      end_burst();
   endtask

   initial begin
      int i;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_stall     = 1'b0;
      hold_left     = 0;
      error_count   = 0;
      beats_sent    = 0;
      beats_checked = 0;
      hit_count     = 0;
      load_count    = 0;
      evict_count   = 0;
      writeback_count  = 0;
      all_pinned_count = 0;
      absent_count     = 0;
      hand_mirror      = 0;
      for (i = 0; i < FRAMES; i++) begin
         tag_mirror[i]    = '0;
         valid_mirror[i]  = 1'b0;
         usage_mirror[i]  = '0;
         pinned_mirror[i] = 1'b0;
         dirty_mirror[i]  = 1'b0;
      end
      for (i = 0; i < POOL_SIZE; i++) page_pool[i] = $urandom;
      send_idle_pct = 30;
      recv_idle_pct = 64;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_all_pinned();
      test_random_traffic(370);
      send_idle_pct = 64;
      recv_idle_pct = 30;
      test_random_traffic(370);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(370);
      test_backpressure();

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request beats sent, %0d results checked, %0d mismatches",
               beats_sent, beats_checked, error_count);
      $display("%0d hits, %0d loads, %0d evictions (%0d writeback), %0d all pinned, %0d absent",
               hit_count, load_count, evict_count, writeback_count, all_pinned_count,
               absent_count);
      if (error_count == 0) begin
         $display("clock_sweep_buffer_replacer_core verification clean");
      end else begin
         $display("clock_sweep_buffer_replacer_core verification failed");
      end
      $finish;
   end

endmodule
